// ===== design/pelbb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pelbb_pkg;

    localparam int COORD_W = 24;
    localparam int LIM_W   = 25;
    localparam int ROOT_W  = 25;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int IDX_W   = 8;
    localparam int UPC_W   = 5;

    localparam logic [LIM_W-1:0] SMALL_RST = 25'd10000;
    localparam logic [LIM_W-1:0] LARGE_RST = 25'd100000;

    // register indexes on the config port
    localparam logic REG_SMALL = 1'b0;
    localparam logic REG_LARGE = 1'b1;

    typedef enum logic [4:0] {
        U_NOP,
        U_LATCH,
        U_SEL_EDGE,
        U_SEL_CLOSE,
        U_SEL_BOX,
        U_MUL_DX,
        U_MUL_DY,
        U_ADD,
        U_ROOT_GO,
        U_MUL_SMALL,
        U_CMP_SMALL,
        U_CMP_LARGE,
        U_EMIT_EDGE,
        U_EMIT_CLOSE,
        U_EMIT_SUM,
        U_UPDATE,
        U_FIRST,
        U_SET_OVF,
        U_CLEAR
    } t_uop;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_IN,
        C_CNT_ZERO,
        C_CNT_FULL,
        C_ROOT_BUSY,
        C_OUT_FULL,
        C_NOT_LAST
    } t_cond;

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    localparam logic [UPC_W-1:0] L_WAIT  = 5'd0;
    localparam logic [UPC_W-1:0] L_FIRST = 5'd11;
    localparam logic [UPC_W-1:0] L_OVF   = 5'd12;
    localparam logic [UPC_W-1:0] L_CHECK = 5'd13;
    localparam logic [UPC_W-1:0] L_NONE  = 5'd0;

    function automatic t_uword uw(input t_uop op, input t_cond cond,
                                  input logic [UPC_W-1:0] target);
        t_uword w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // Control store: on a true condition the step jumps to target,
    // otherwise it falls through. Emit steps hold while the output is full.
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        unique case (pc)
            5'd0:    w = uw(U_LATCH,     C_NO_IN,     L_WAIT);
            5'd1:    w = uw(U_NOP,       C_CNT_ZERO,  L_FIRST);
            5'd2:    w = uw(U_NOP,       C_CNT_FULL,  L_OVF);
            5'd3:    w = uw(U_SEL_EDGE,  C_NEVER,     L_NONE);
            5'd4:    w = uw(U_MUL_DX,    C_NEVER,     L_NONE);
            5'd5:    w = uw(U_MUL_DY,    C_NEVER,     L_NONE);
            5'd6:    w = uw(U_ADD,       C_NEVER,     L_NONE);
            5'd7:    w = uw(U_ROOT_GO,   C_NEVER,     L_NONE);
            5'd8:    w = uw(U_NOP,       C_ROOT_BUSY, 5'd8);
            5'd9:    w = uw(U_EMIT_EDGE, C_OUT_FULL,  5'd9);
            5'd10:   w = uw(U_UPDATE,    C_ALWAYS,    L_CHECK);
            5'd11:   w = uw(U_FIRST,     C_ALWAYS,    L_CHECK);
            5'd12:   w = uw(U_SET_OVF,   C_NEVER,     L_NONE);
            5'd13:   w = uw(U_NOP,       C_NOT_LAST,  L_WAIT);
            5'd14:   w = uw(U_SEL_CLOSE, C_NEVER,     L_NONE);
            5'd15:   w = uw(U_MUL_DX,    C_NEVER,     L_NONE);
            5'd16:   w = uw(U_MUL_DY,    C_NEVER,     L_NONE);
            5'd17:   w = uw(U_ADD,       C_NEVER,     L_NONE);
            5'd18:   w = uw(U_ROOT_GO,   C_NEVER,     L_NONE);
            5'd19:   w = uw(U_NOP,       C_ROOT_BUSY, 5'd19);
            5'd20:   w = uw(U_EMIT_CLOSE, C_OUT_FULL, 5'd20);
            5'd21:   w = uw(U_SEL_BOX,   C_NEVER,     L_NONE);
            5'd22:   w = uw(U_MUL_DX,    C_NEVER,     L_NONE);
            5'd23:   w = uw(U_MUL_DY,    C_NEVER,     L_NONE);
            5'd24:   w = uw(U_ADD,       C_NEVER,     L_NONE);
            5'd25:   w = uw(U_ROOT_GO,   C_NEVER,     L_NONE);
            5'd26:   w = uw(U_MUL_SMALL, C_NEVER,     L_NONE);
            5'd27:   w = uw(U_CMP_SMALL, C_NEVER,     L_NONE);
            5'd28:   w = uw(U_CMP_LARGE, C_NEVER,     L_NONE);
            5'd29:   w = uw(U_NOP,       C_ROOT_BUSY, 5'd29);
            5'd30:   w = uw(U_EMIT_SUM,  C_OUT_FULL,  5'd30);
            5'd31:   w = uw(U_CLEAR,     C_ALWAYS,    L_WAIT);
            default: w = uw(U_NOP,       C_ALWAYS,    L_WAIT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/polygon_edge_length_bounding_box.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Polygon edge lengths and bounding box.
// Input channel (i_in_valid / o_in_stall): one vertex per item, signed mm
// coordinates, i_last_vertex on the final vertex of a polygon.
// Output channel (o_out_valid / i_out_stall): edge items (kind 0) and one
// summary item (kind 1) after the closing edge; o_last marks the final
// result of a vertex. A first vertex, or one beyond MAX_VERTICES, gives none.
// APB port: small limit at 0x0, large limit at 0x4, 25 bits, pready high.
// Sequencing: a microcoded sequencer runs one vertex at a time. An ordinary
// vertex waits on the 25-step square root unit before its edge item loads.
// The last vertex adds two more roots, for the closing edge and the box
// diagonal. A first vertex, or an overflowing one, skips the edge steps.
// o_in_stall is high while a vertex is being worked on.
// A single output register holds each result; while the receiver stalls,
// the sequencer waits at its emit step and nothing is lost.
// Reset (synchronous, active low) clears the polygon state and restores the
// limits to 10000 and 100000 mm.
module polygon_edge_length_bounding_box #(
    parameter int MAX_VERTICES = 256
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // config
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic      [31:0]                         prdata,
    output logic                                     pready,
    // vertices
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic signed [pelbb_pkg::COORD_W-1:0] i_vertex_x,
    input  wire logic signed [pelbb_pkg::COORD_W-1:0] i_vertex_y,
    input  wire logic                                i_last_vertex,
    // results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_kind,
    output logic      [pelbb_pkg::IDX_W-1:0]         o_edge_index,
    output logic      [pelbb_pkg::ROOT_W-1:0]        o_edge_length,
    output logic signed [pelbb_pkg::COORD_W-1:0]     o_min_x,
    output logic signed [pelbb_pkg::COORD_W-1:0]     o_max_x,
    output logic signed [pelbb_pkg::COORD_W-1:0]     o_min_y,
    output logic signed [pelbb_pkg::COORD_W-1:0]     o_max_y,
    output logic      [pelbb_pkg::ROOT_W-1:0]        o_diag_mm,
    output logic                                     o_too_small,
    output logic                                     o_too_large,
    output logic                                     o_overflow,
    output logic                                     o_last
);

    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int EW = (CW > pelbb_pkg::IDX_W) ? CW : pelbb_pkg::IDX_W;
    localparam int CO = pelbb_pkg::COORD_W;

    // ---- config registers ----
    logic [pelbb_pkg::LIM_W-1:0] r_small;
    logic [pelbb_pkg::LIM_W-1:0] r_large;
    logic                        w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[2])
            pelbb_pkg::REG_SMALL: prdata = {7'd0, r_small};
            pelbb_pkg::REG_LARGE: prdata = {7'd0, r_large};
            default:              prdata = '0;
        endcase
    end

    // ---- sequencer ----
    logic [pelbb_pkg::UPC_W-1:0] r_pc;
    logic [pelbb_pkg::UPC_W-1:0] n_pc;
    pelbb_pkg::t_uword           w_uw;
    logic                        w_take;
    logic                        w_accept;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_load;
    logic                        w_root_busy;

    // polygon state
    logic signed [CO-1:0] r_first_x, r_first_y, r_prev_x, r_prev_y;
    logic signed [CO-1:0] r_bmin_x, r_bmax_x, r_bmin_y, r_bmax_y;
    logic        [CW-1:0] r_count;
    logic                 r_ovf;

    // latched vertex
    logic signed [CO-1:0] r_in_x, r_in_y;
    logic                 r_in_last;

    assign w_uw       = pelbb_pkg::ucode(r_pc);
    assign o_in_stall = (r_pc != pelbb_pkg::L_WAIT) || !i_rst_n;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !o_out_valid || !i_out_stall;
    assign w_emit     = (w_uw.op == pelbb_pkg::U_EMIT_EDGE)
                     || (w_uw.op == pelbb_pkg::U_EMIT_CLOSE)
                     || (w_uw.op == pelbb_pkg::U_EMIT_SUM);
    assign w_load     = w_emit && w_out_free;

    always_comb begin
        unique case (w_uw.cond)
            pelbb_pkg::C_NEVER:     w_take = 1'b0;
            pelbb_pkg::C_ALWAYS:    w_take = 1'b1;
            pelbb_pkg::C_NO_IN:     w_take = !w_accept;
            pelbb_pkg::C_CNT_ZERO:  w_take = (r_count == '0);
            pelbb_pkg::C_CNT_FULL:  w_take = (r_count >= CW'(MAX_VERTICES));
            pelbb_pkg::C_ROOT_BUSY: w_take = w_root_busy;
            pelbb_pkg::C_OUT_FULL:  w_take = !w_out_free;
            pelbb_pkg::C_NOT_LAST:  w_take = !r_in_last;
            default:                w_take = 1'b0;
        endcase
        n_pc = w_take ? w_uw.target : r_pc + 1'b1;
    end

    // ---- difference unit: |a - b| on both axes ----
    logic signed [CO-1:0] w_ax, w_bx, w_ay, w_by;
    logic signed [CO:0]   w_dxs, w_dys, w_ndx, w_ndy;
    logic        [CO-1:0] w_adx, w_ady;
    logic        [CO-1:0] r_dx, r_dy;

    always_comb begin
        unique case (w_uw.op)
            pelbb_pkg::U_SEL_CLOSE: begin
                w_ax = r_first_x; w_bx = r_prev_x;
                w_ay = r_first_y; w_by = r_prev_y;
            end
            pelbb_pkg::U_SEL_BOX: begin
                w_ax = r_bmax_x; w_bx = r_bmin_x;
                w_ay = r_bmax_y; w_by = r_bmin_y;
            end
            default: begin
                w_ax = r_in_x; w_bx = r_prev_x;
                w_ay = r_in_y; w_by = r_prev_y;
            end
        endcase
    end

    assign w_dxs = {w_ax[CO-1], w_ax} - {w_bx[CO-1], w_bx};
    assign w_dys = {w_ay[CO-1], w_ay} - {w_by[CO-1], w_by};
    assign w_ndx = -w_dxs;
    assign w_ndy = -w_dys;
    assign w_adx = w_dxs[CO] ? w_ndx[CO-1:0] : w_dxs[CO-1:0];
    assign w_ady = w_dys[CO] ? w_ndy[CO-1:0] : w_dys[CO-1:0];

    // ---- squarer, shared by distances and limits ----
    logic [pelbb_pkg::LIM_W-1:0] w_mop;
    logic [pelbb_pkg::SQ_W-1:0]  r_prod;
    logic [pelbb_pkg::SQ_W-1:0]  r_sq;
    logic                        w_mul;
    logic                        r_small_f, r_large_f;

    always_comb begin
        unique case (w_uw.op)
            pelbb_pkg::U_MUL_DY:    w_mop = {1'b0, r_dy};
            pelbb_pkg::U_MUL_SMALL: w_mop = r_small;
            pelbb_pkg::U_CMP_SMALL: w_mop = r_large;
            default:                w_mop = {1'b0, r_dx};
        endcase
    end

    assign w_mul = (w_uw.op == pelbb_pkg::U_MUL_DX) || (w_uw.op == pelbb_pkg::U_MUL_DY)
                || (w_uw.op == pelbb_pkg::U_MUL_SMALL) || (w_uw.op == pelbb_pkg::U_CMP_SMALL);

    // ---- square root unit ----
    logic [pelbb_pkg::ROOT_W-1:0] w_root;

    pelbb_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_uw.op == pelbb_pkg::U_ROOT_GO),
        .i_radicand (r_sq),
        .o_busy     (w_root_busy),
        .o_root     (w_root)
    );

    // edge index: starting vertex of the edge, low bits
    logic [EW-1:0] w_idx;
    assign w_idx = EW'(r_count) - EW'(1);

    // ---- control registers ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= pelbb_pkg::L_WAIT;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            o_out_valid <= 1'b0;
            r_small     <= pelbb_pkg::SMALL_RST;
            r_large     <= pelbb_pkg::LARGE_RST;
        end else begin
            r_pc <= n_pc;
            if (w_cfg_wr) begin
                if (paddr[2] == pelbb_pkg::REG_SMALL) begin
                    r_small <= pwdata[pelbb_pkg::LIM_W-1:0];
                end else begin
                    r_large <= pwdata[pelbb_pkg::LIM_W-1:0];
                end
            end
            if (w_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
            unique case (w_uw.op)
                pelbb_pkg::U_FIRST:   r_count <= CW'(1);
                pelbb_pkg::U_UPDATE:  r_count <= r_count + 1'b1;
                pelbb_pkg::U_SET_OVF: r_ovf   <= 1'b1;
                pelbb_pkg::U_CLEAR: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        if (w_mul) begin
            r_prod <= pelbb_pkg::SQ_W'(w_mop) * pelbb_pkg::SQ_W'(w_mop);
        end
        case (w_uw.op)
            pelbb_pkg::U_LATCH: begin
                if (w_accept) begin
                    r_in_x    <= i_vertex_x;
                    r_in_y    <= i_vertex_y;
                    r_in_last <= i_last_vertex;
                end
            end
            pelbb_pkg::U_SEL_EDGE, pelbb_pkg::U_SEL_CLOSE, pelbb_pkg::U_SEL_BOX: begin
                r_dx <= w_adx;
                r_dy <= w_ady;
            end
            pelbb_pkg::U_MUL_DY:    r_sq      <= r_prod;
            pelbb_pkg::U_ADD:       r_sq      <= r_sq + r_prod;
            pelbb_pkg::U_CMP_SMALL: r_small_f <= (r_sq < r_prod);
            pelbb_pkg::U_CMP_LARGE: r_large_f <= (r_sq > r_prod);
            pelbb_pkg::U_FIRST: begin
                r_first_x <= r_in_x; r_first_y <= r_in_y;
                r_prev_x  <= r_in_x; r_prev_y  <= r_in_y;
                r_bmin_x  <= r_in_x; r_bmax_x  <= r_in_x;
                r_bmin_y  <= r_in_y; r_bmax_y  <= r_in_y;
            end
            pelbb_pkg::U_UPDATE: begin
                if (r_in_x < r_bmin_x) r_bmin_x <= r_in_x;
                if (r_in_x > r_bmax_x) r_bmax_x <= r_in_x;
                if (r_in_y < r_bmin_y) r_bmin_y <= r_in_y;
                if (r_in_y > r_bmax_y) r_bmax_y <= r_in_y;
                r_prev_x <= r_in_x;
                r_prev_y <= r_in_y;
            end
            default: ;
        endcase

        // result register
        if (w_load) begin
            o_overflow <= r_ovf;
            if (w_uw.op == pelbb_pkg::U_EMIT_SUM) begin
                o_kind        <= 1'b1;
                o_edge_index  <= '0;
                o_edge_length <= '0;
                o_min_x       <= r_bmin_x;
                o_max_x       <= r_bmax_x;
                o_min_y       <= r_bmin_y;
                o_max_y       <= r_bmax_y;
                o_diag_mm     <= w_root;
                o_too_small   <= r_small_f;
                o_too_large   <= r_large_f;
                o_last        <= 1'b1;
            end else begin
                o_kind        <= 1'b0;
                o_edge_index  <= w_idx[pelbb_pkg::IDX_W-1:0];
                o_edge_length <= w_root;
                o_min_x       <= '0;
                o_max_x       <= '0;
                o_min_y       <= '0;
                o_max_y       <= '0;
                o_diag_mm     <= '0;
                o_too_small   <= 1'b0;
                o_too_large   <= 1'b0;
                // the closing edge is always followed by the summary
                o_last        <= (w_uw.op == pelbb_pkg::U_EMIT_EDGE) && !r_in_last;
            end
        end
    end

    // ---- assertions ----
    a_no_emit_mid_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> !w_root_busy)
        else $error("result loaded while square root still running");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_VERTICES))
        else $error("vertex count beyond maximum");

    a_clear_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && (w_uw.op == pelbb_pkg::U_EMIT_SUM)) |=> ##1 (r_count == '0 && !r_ovf))
        else $error("polygon state not cleared after summary");

    a_sum_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_kind) |-> o_last)
        else $error("summary item without last flag");

endmodule

`default_nettype wire

// ===== design/pelbb_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Restoring square root, two radicand bits per cycle.
module pelbb_isqrt (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_start,
    input  wire logic [pelbb_pkg::SQ_W-1:0]   i_radicand,
    output logic                              o_busy,
    output logic      [pelbb_pkg::ROOT_W-1:0] o_root
);

    localparam int REM_W = pelbb_pkg::ROOT_W + 2;
    localparam int CNT_W = $clog2(pelbb_pkg::ROOT_W);

    logic [pelbb_pkg::SQ_W-1:0]   r_rad;
    logic [REM_W-1:0]             r_rem;
    logic [pelbb_pkg::ROOT_W-1:0] r_root;
    logic [CNT_W-1:0]             r_cnt;
    logic                         r_busy;

    logic [REM_W-1:0] w_rem_sh;
    logic [REM_W-1:0] w_trial;
    logic [REM_W-1:0] w_diff;
    logic             w_ge;

    assign w_rem_sh = {r_rem[pelbb_pkg::ROOT_W-1:0], r_rad[pelbb_pkg::SQ_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(pelbb_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= i_radicand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[pelbb_pkg::SQ_W-3:0], 2'b00};
            r_rem  <= w_ge ? w_diff : w_rem_sh;
            r_root <= {r_root[pelbb_pkg::ROOT_W-2:0], w_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

`default_nettype wire
